// ===== hdl/tfdb_pkg.sv =====
// Shared types and constants for the triangle fragment depth/blend block.
// No dependencies; all other files but the two interfaces and tfdb_div import it.
package tfdb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 256;
    localparam int SCREEN_HEIGHT_DEF = 256;
    localparam int STORE_AW          = 16;
    localparam int STORE_DEPTH       = 1 << STORE_AW;
    localparam logic signed [15:0] DEPTH_FAR  = 16'sh7FFF;
    localparam logic signed [15:0] DEPTH_NEAR = 16'sh8000;
    localparam logic [31:0] BLEND_RECIP = 32'd32897;   // 2^23 / 255, rounded up
    localparam int          BLEND_SHIFT = 23;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FRAG = 1'b1;
    localparam logic [1:0] SLOT_MAX = 2'd2;

    typedef enum logic [1:0] {
        ST_REJECT     = 2'd0,
        ST_DEPTH_FAIL = 2'd1,
        ST_WRITTEN    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_EDGE
    } front_state_t;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_WSTART,
        B_WDIV,
        B_MUL,
        B_DSTART,
        B_DDIV,
        B_READ,
        B_CMP,
        B_BLEND,
        B_OUT
    } back_state_t;

    // Classified fragment handed from front to back.
    typedef struct packed {
        logic signed [28:0] ea;
        logic signed [28:0] eb;
        logic signed [28:0] ec;
        logic signed [15:0] z0;
        logic signed [15:0] z1;
        logic signed [15:0] z2;
        logic [23:0]        rhw0;
        logic [23:0]        rhw1;
        logic [23:0]        rhw2;
        logic [7:0]         px;
        logic [7:0]         py;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [7:0]         a;
        logic               off;
    } frag_t;

endpackage

// ===== hdl/tfdb_in_if.sv =====
// Input channel: valid/ready handshake with vertex load and fragment payload.
// No dependencies.
interface tfdb_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [1:0]         vertex_slot;
    logic [12:0]        vert_x;
    logic [12:0]        vert_y;
    logic signed [15:0] vert_z;
    logic [23:0]        vert_rhw;
    logic [7:0]         pixel_x;
    logic [7:0]         pixel_y;
    logic [7:0]         src_r;
    logic [7:0]         src_g;
    logic [7:0]         src_b;
    logic [7:0]         src_alpha;

    modport source (output valid, opcode, vertex_slot, vert_x, vert_y, vert_z, vert_rhw,
                    pixel_x, pixel_y, src_r, src_g, src_b, src_alpha, input ready);
    modport sink (input valid, opcode, vertex_slot, vert_x, vert_y, vert_z, vert_rhw,
                  pixel_x, pixel_y, src_r, src_g, src_b, src_alpha, output ready);
endinterface

// ===== hdl/tfdb_out_if.sv =====
// Output channel: valid/ready handshake carrying one fragment result.
// No dependencies.
interface tfdb_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [7:0]         out_x;
    logic [7:0]         out_y;
    logic [7:0]         out_r;
    logic [7:0]         out_g;
    logic [7:0]         out_b;
    logic signed [15:0] out_depth;

    modport source (output valid, status, out_x, out_y, out_r, out_g, out_b, out_depth,
                    input ready);
    modport sink (input valid, status, out_x, out_y, out_r, out_g, out_b, out_depth,
                  output ready);
endinterface

// ===== hdl/triangle_fragment_depth_blend.sv =====
// Triangle fragment back end with a 256x256 depth/color store and alpha blend.
// After reset the block clears all 65536 entries of the store before it takes
// any item. A fragment forms its edge products in the front and then, from
// leaving the queue to the result transfer, runs in the back: the shared
// 16-step divider runs up to four times (three barycentric weights and the
// perspective depth), then come the accumulate steps and the store read,
// compare, blend/write and output steps. A rejected fragment goes straight to
// the output state in the back; a weight of exactly 1.0, a zero or saturating
// depth division and a failed depth test each skip part of that.
// A two-entry queue lets loads and further fragments enter while the back works.
// Depends on tfdb_pkg, the channel interfaces, tfdb_front, tfdb_queue, tfdb_back.
module triangle_fragment_depth_blend
    import tfdb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    tfdb_in_if.sink    in_ch,
    tfdb_out_if.source out_ch
);
    logic  clearing;
    logic  q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    frag_t q_wr_data, q_rd_data;

    tfdb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .hold     (clearing),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data)
    );

    tfdb_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    tfdb_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data),
        .out_ch   (out_ch),
        .clearing (clearing)
    );

endmodule

// ===== hdl/tfdb_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 16 bits per run.
// Depends on nothing but its ports.
module tfdb_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [29:0] rem_init,   // must be below divisor
    input  logic [29:0] divisor,
    input  logic [15:0] low,        // dividend bits shifted in below rem_init
    output logic        done,
    output logic [15:0] quot
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [29:0] rem_reg, rem_next;
    logic [29:0] div_reg, div_next;
    logic [15:0] low_reg, low_next;
    logic [15:0] q_reg, q_next;
    logic [30:0] trial;
    logic        ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    always_comb
    begin
        trial     = {rem_reg, low_reg[15]};
        ge        = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = rem_init;
            div_next  = divisor;
            low_next  = low;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 30'(trial - {1'b0, div_reg}) : trial[29:0];
            low_next = {low_reg[14:0], 1'b0};
            q_next   = {q_reg[14:0], ge};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'hF)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ===== hdl/tfdb_front.sv =====
// Front end: accepts items, holds the triangle corners, forms edge values
// and pushes classified fragments. Depends on tfdb_pkg and tfdb_in_if.
module tfdb_front
    import tfdb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    tfdb_in_if.sink in_ch,
    input  logic   hold,
    output logic   wr_valid,
    input  logic   wr_ready,
    output frag_t  wr_data
);
    front_state_t state_reg, state_next;

    logic [12:0]        cx_reg [3];
    logic [12:0]        cy_reg [3];
    logic signed [15:0] cz_reg [3];
    logic [23:0]        crhw_reg [3];

    logic signed [13:0] dx_reg [3];
    logic signed [13:0] dy_reg [3];
    logic signed [27:0] pl_reg [3];
    logic signed [27:0] pr_reg [3];
    frag_t              hold_reg;   // payload snapshot of the fragment in flight

    logic               take;
    logic [13:0]        ctr_x, ctr_y;
    logic signed [28:0] e [3];

    assign in_ch.ready = (state_reg == F_IDLE) && !hold;
    assign take        = in_ch.valid && in_ch.ready;
    assign ctr_x       = {2'b00, in_ch.pixel_x, 4'b1000};
    assign ctr_y       = {2'b00, in_ch.pixel_y, 4'b1000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            for (int k = 0; k < 3; k++)
            begin
                cx_reg[k]   <= '0;
                cy_reg[k]   <= '0;
                cz_reg[k]   <= '0;
                crhw_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (take && in_ch.opcode == OP_LOAD && in_ch.vertex_slot <= SLOT_MAX)
            begin
                cx_reg[in_ch.vertex_slot]   <= in_ch.vert_x;
                cy_reg[in_ch.vertex_slot]   <= in_ch.vert_y;
                cz_reg[in_ch.vertex_slot]   <= in_ch.vert_z;
                crhw_reg[in_ch.vertex_slot] <= in_ch.vert_rhw;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dx_reg[k] <= $signed({1'b0, cx_reg[k]}) - $signed(ctr_x);
                dy_reg[k] <= $signed({1'b0, cy_reg[k]}) - $signed(ctr_y);
            end
            hold_reg.z0   <= cz_reg[0];
            hold_reg.z1   <= cz_reg[1];
            hold_reg.z2   <= cz_reg[2];
            hold_reg.rhw0 <= crhw_reg[0];
            hold_reg.rhw1 <= crhw_reg[1];
            hold_reg.rhw2 <= crhw_reg[2];
            hold_reg.px   <= in_ch.pixel_x;
            hold_reg.py   <= in_ch.pixel_y;
            hold_reg.r    <= in_ch.src_r;
            hold_reg.g    <= in_ch.src_g;
            hold_reg.b    <= in_ch.src_b;
            hold_reg.a    <= in_ch.src_alpha;
            hold_reg.off  <= (32'(in_ch.pixel_x) >= 32'(SCREEN_WIDTH)) ||
                             (32'(in_ch.pixel_y) >= 32'(SCREEN_HEIGHT));
            hold_reg.ea   <= '0;
            hold_reg.eb   <= '0;
            hold_reg.ec   <= '0;
        end
        if (state_reg == F_MUL)
        begin
            // edge k uses corners k+1 and k+2
            pl_reg[0] <= dy_reg[1] * dx_reg[2];
            pr_reg[0] <= dx_reg[1] * dy_reg[2];
            pl_reg[1] <= dy_reg[2] * dx_reg[0];
            pr_reg[1] <= dx_reg[2] * dy_reg[0];
            pl_reg[2] <= dy_reg[0] * dx_reg[1];
            pr_reg[2] <= dx_reg[0] * dy_reg[1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e[k] = $signed({pl_reg[k][27], pl_reg[k]}) - $signed({pr_reg[k][27], pr_reg[k]});
        end
        wr_data    = hold_reg;
        wr_data.ea = e[0];
        wr_data.eb = e[1];
        wr_data.ec = e[2];
        wr_valid   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (take && in_ch.opcode == OP_FRAG)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_EDGE;
            end
            F_EDGE:
            begin
                wr_valid = 1'b1;
                if (wr_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/tfdb_queue.sv =====
// Two-entry queue of classified fragments between front and back.
// Depends on tfdb_pkg.
module tfdb_queue
    import tfdb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  frag_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output frag_t rd_data
);
    frag_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/tfdb_back.sv =====
// Back end: barycentric weights, depth, depth test, blend and the pixel
// store. Depends on tfdb_pkg, tfdb_out_if and tfdb_div.
module tfdb_back
    import tfdb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   rd_valid,
    output logic   rd_ready,
    input  frag_t  rd_data,
    tfdb_out_if.source out_ch,
    output logic   clearing
);
    back_state_t state_reg, state_next;

    // depth in 39:24, color in 23:0
    logic [39:0] store_mem [STORE_DEPTH];
    logic [39:0] rdata_reg;

    frag_t              ent_reg, ent_next;
    logic [29:0]        s_reg, s_next;
    logic [16:0]        w_reg [3];
    logic [16:0]        w_next [3];
    logic [1:0]         sel_reg, sel_next;
    logic [40:0]        prod_rhw_reg, prod_rhw_next;
    logic signed [33:0] prod_z_reg, prod_z_next;
    logic [41:0]        acc_rhw_reg, acc_rhw_next;
    logic signed [35:0] acc_z_reg, acc_z_next;
    logic signed [15:0] depth_reg, depth_next;
    logic [15:0]        x_reg [3];
    logic [15:0]        x_next [3];
    logic [15:0]        clr_reg, clr_next;
    logic [1:0]         status_reg, status_next;
    logic [7:0]         or_reg, og_reg, ob_reg, or_next, og_next, ob_next;
    logic signed [15:0] odepth_reg, odepth_next;

    logic               mem_we, mem_re;
    logic [15:0]        mem_addr;
    logic [39:0]        mem_wdata;

    logic               div_start, div_done;
    logic [29:0]        div_rem, div_den;
    logic [15:0]        div_low, div_quot;

    logic signed [30:0] s_full;
    logic [29:0]        e_sel;
    logic [16:0]        w_sel;
    logic [23:0]        rhw_sel;
    logic signed [15:0] z_sel;
    logic [25:0]        rhw_i;
    logic [35:0]        mag;
    logic [7:0]         src [3];
    logic [7:0]         dst [3];
    logic [31:0]        qprod [3];

    tfdb_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .divisor  (div_den),
        .low      (div_low),
        .done     (div_done),
        .quot     (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        s_reg        <= s_next;
        sel_reg      <= sel_next;
        prod_rhw_reg <= prod_rhw_next;
        prod_z_reg   <= prod_z_next;
        acc_rhw_reg  <= acc_rhw_next;
        acc_z_reg    <= acc_z_next;
        depth_reg    <= depth_next;
        status_reg   <= status_next;
        or_reg       <= or_next;
        og_reg       <= og_next;
        ob_reg       <= ob_next;
        odepth_reg   <= odepth_next;
        for (int k = 0; k < 3; k++)
        begin
            w_reg[k] <= w_next[k];
            x_reg[k] <= x_next[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[mem_addr];
        end
    end

    always_comb
    begin
        s_full = $signed({{2{rd_data.ea[28]}}, rd_data.ea})
               + $signed({{2{rd_data.eb[28]}}, rd_data.eb})
               + $signed({{2{rd_data.ec[28]}}, rd_data.ec});
        case (sel_reg)
            2'd0:
            begin
                e_sel   = {2'b00, ent_reg.ea[27:0]};
                rhw_sel = ent_reg.rhw0;
                z_sel   = ent_reg.z0;
            end
            2'd1:
            begin
                e_sel   = {2'b00, ent_reg.eb[27:0]};
                rhw_sel = ent_reg.rhw1;
                z_sel   = ent_reg.z1;
            end
            default:
            begin
                e_sel   = {2'b00, ent_reg.ec[27:0]};
                rhw_sel = ent_reg.rhw2;
                z_sel   = ent_reg.z2;
            end
        endcase
        w_sel = (sel_reg == 2'd0) ? w_reg[0] : (sel_reg == 2'd1) ? w_reg[1] : w_reg[2];
        rhw_i = acc_rhw_reg[41:16];
        mag   = acc_z_reg[35] ? 36'(-acc_z_reg) : 36'(acc_z_reg);
        src[0] = ent_reg.r;
        src[1] = ent_reg.g;
        src[2] = ent_reg.b;
        dst[0] = rdata_reg[23:16];
        dst[1] = rdata_reg[15:8];
        dst[2] = rdata_reg[7:0];
        for (int k = 0; k < 3; k++)
        begin
            qprod[k] = {16'h0000, x_reg[k]} * BLEND_RECIP;
        end

        state_next    = state_reg;
        ent_next      = ent_reg;
        s_next        = s_reg;
        sel_next      = sel_reg;
        prod_rhw_next = prod_rhw_reg;
        prod_z_next   = prod_z_reg;
        acc_rhw_next  = acc_rhw_reg;
        acc_z_next    = acc_z_reg;
        depth_next    = depth_reg;
        status_next   = status_reg;
        or_next       = or_reg;
        og_next       = og_reg;
        ob_next       = ob_reg;
        odepth_next   = odepth_reg;
        clr_next      = clr_reg;
        for (int k = 0; k < 3; k++)
        begin
            w_next[k] = w_reg[k];
            x_next[k] = x_reg[k];
        end
        rd_ready  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = {ent_reg.py, ent_reg.px};
        mem_wdata = {depth_reg, 8'(qprod[0][30:BLEND_SHIFT]), 8'(qprod[1][30:BLEND_SHIFT]),
                     8'(qprod[2][30:BLEND_SHIFT])};
        div_start = 1'b0;
        div_rem   = e_sel;
        div_den   = s_reg;
        div_low   = '0;

        case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = {DEPTH_FAR, 24'h000000};
                clr_next  = clr_reg + 16'd1;
                if (clr_reg == 16'hFFFF)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                rd_ready = 1'b1;
                if (rd_valid)
                begin
                    ent_next = rd_data;
                    s_next   = s_full[29:0];
                    sel_next = 2'd0;
                    if (rd_data.off || rd_data.ea < 0 || rd_data.eb < 0 || rd_data.ec < 0 ||
                        s_full == 0)
                    begin
                        status_next = ST_REJECT;
                        or_next     = '0;
                        og_next     = '0;
                        ob_next     = '0;
                        odepth_next = '0;
                        state_next  = B_OUT;
                    end
                    else
                    begin
                        state_next = B_WSTART;
                    end
                end
            end
            B_WSTART:
            begin
                // an edge equal to the whole area gives weight 1.0 exactly
                if (e_sel == s_reg)
                begin
                    w_next[sel_reg] = 17'h10000;
                    sel_next        = sel_reg + 2'd1;
                    if (sel_reg == 2'd2)
                    begin
                        sel_next     = 2'd0;
                        acc_rhw_next = '0;
                        acc_z_next   = '0;
                        state_next   = B_MUL;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = B_WDIV;
                end
            end
            B_WDIV:
            begin
                if (div_done)
                begin
                    w_next[sel_reg] = {1'b0, div_quot};
                    sel_next        = sel_reg + 2'd1;
                    state_next      = B_WSTART;
                    if (sel_reg == 2'd2)
                    begin
                        sel_next     = 2'd0;
                        acc_rhw_next = '0;
                        acc_z_next   = '0;
                        state_next   = B_MUL;
                    end
                end
            end
            B_MUL:
            begin
                // products of one corner per cycle, accumulated in the cycle after
                prod_rhw_next = {24'h000000, w_sel} * {17'h00000, rhw_sel};
                prod_z_next   = $signed({1'b0, w_sel}) * z_sel;
                sel_next      = sel_reg + 2'd1;
                if (sel_reg != 2'd0)
                begin
                    acc_rhw_next = acc_rhw_reg + {1'b0, prod_rhw_reg};
                    acc_z_next   = acc_z_reg + 36'(prod_z_reg);
                end
                if (sel_reg == 2'd3)
                begin
                    state_next = B_DSTART;
                end
            end
            B_DSTART:
            begin
                div_rem = {11'h000, mag[34:16]};
                div_den = {4'h0, rhw_i};
                div_low = mag[15:0];
                if (rhw_i == '0)
                begin
                    depth_next = DEPTH_FAR;
                    state_next = B_READ;
                end
                else if ({7'h00, mag[34:16]} >= rhw_i)
                begin
                    depth_next = acc_z_reg[35] ? DEPTH_NEAR : DEPTH_FAR;
                    state_next = B_READ;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = B_DDIV;
                end
            end
            B_DDIV:
            begin
                div_rem = {11'h000, mag[34:16]};
                div_den = {4'h0, rhw_i};
                div_low = mag[15:0];
                if (div_done)
                begin
                    if (acc_z_reg[35])
                    begin
                        depth_next = (div_quot > 16'h8000) ? DEPTH_NEAR
                                   : 16'(-$signed({1'b0, div_quot}));
                    end
                    else
                    begin
                        depth_next = (div_quot > 16'h7FFF) ? DEPTH_FAR : $signed(div_quot);
                    end
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                mem_re     = 1'b1;
                state_next = B_CMP;
            end
            B_CMP:
            begin
                if (depth_reg >= $signed(rdata_reg[39:24]))
                begin
                    status_next = ST_DEPTH_FAIL;
                    or_next     = '0;
                    og_next     = '0;
                    ob_next     = '0;
                    odepth_next = depth_reg;
                    state_next  = B_OUT;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        x_next[k] = 16'({8'h00, ent_reg.a} * {8'h00, src[k]}
                                  + {8'h00, 8'hFF - ent_reg.a} * {8'h00, dst[k]} + 16'd127);
                    end
                    state_next = B_BLEND;
                end
            end
            B_BLEND:
            begin
                mem_we      = 1'b1;
                status_next = ST_WRITTEN;
                or_next     = qprod[0][30:BLEND_SHIFT];
                og_next     = qprod[1][30:BLEND_SHIFT];
                ob_next     = qprod[2][30:BLEND_SHIFT];
                odepth_next = depth_reg;
                state_next  = B_OUT;
            end
            B_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign clearing         = state_reg == B_CLEAR;
    assign out_ch.valid     = state_reg == B_OUT;
    assign out_ch.status    = status_reg;
    assign out_ch.out_x     = ent_reg.px;
    assign out_ch.out_y     = ent_reg.py;
    assign out_ch.out_r     = or_reg;
    assign out_ch.out_g     = og_reg;
    assign out_ch.out_b     = ob_reg;
    assign out_ch.out_depth = odepth_reg;

endmodule

// ===== hdl/tfdb_checker.sv =====
// Port-level checks for triangle_fragment_depth_blend, bound to the top level.
// Depends on tfdb_pkg.
module tfdb_checker
    import tfdb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [7:0]  out_r,
    input logic [7:0]  out_g,
    input logic [7:0]  out_b,
    input logic [15:0] out_depth
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_depth))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_REJECT || status == ST_DEPTH_FAIL ||
                       status == ST_WRITTEN))
        else $error("unknown status code");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_REJECT |->
            out_r == 8'd0 && out_g == 8'd0 && out_b == 8'd0 && out_depth == 16'd0)
        else $error("rejected fragment carries data");

    a_fail_no_color: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DEPTH_FAIL |->
            out_r == 8'd0 && out_g == 8'd0 && out_b == 8'd0)
        else $error("failed depth test carries color");

endmodule

bind triangle_fragment_depth_blend tfdb_checker u_tfdb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (out_ch.status),
    .out_r     (out_ch.out_r),
    .out_g     (out_ch.out_g),
    .out_b     (out_ch.out_b),
    .out_depth (out_ch.out_depth)
);

// ===== bench/tb_triangle_fragment_depth_blend.sv =====
// Testbench for triangle_fragment_depth_blend: drives vertex loads and fragments,
// predicts status/depth/color with its own raster model and checks every result.
// Depends on tfdb_pkg, tfdb_in_if, tfdb_out_if and the block itself.
`timescale 1ns / 1ps

module tb_triangle_fragment_depth_blend;
    import tfdb_pkg::*;

    typedef struct {
        logic        opcode;
        logic [1:0]  slot;
        logic [12:0] vx;
        logic [12:0] vy;
        logic [15:0] vz;
        logic [23:0] vrhw;
        logic [7:0]  px;
        logic [7:0]  py;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
    } item_t;

    typedef struct {
        status_t     status;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [15:0] depth;
    } frag_result_t;

    localparam int WATCHDOG_LIMIT = 200000;

    logic clk;
    logic rst_n;
    tfdb_in_if  in_ch ();
    tfdb_out_if out_ch ();

    triangle_fragment_depth_blend DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predictor state
    logic [12:0]        tri_x [3];
    logic [12:0]        tri_y [3];
    logic signed [15:0] tri_z [3];
    logic [23:0]        tri_rhw [3];
    logic signed [15:0] zbuf [STORE_DEPTH];
    logic [23:0]        cbuf [STORE_DEPTH];

    item_t        pending_items[$];
    frag_result_t expected_frags[$];
    int  errors;
    int  idle_cycles;
    bit  stim_done;
    bit  calm;
    bit  hold_off_req;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] s, logic [7:0] d);
        int unsigned v;
        v = (a * s + (255 - a) * d + 127) / 255;
        return v[7:0];
    endfunction

    function automatic longint edge_fn(longint ux, longint uy, longint vx, longint vy);
        return -(ux * vy - uy * vx);
    endfunction

    task automatic shade_fragment(input item_t it);
        frag_result_t res;
        longint cx, cy, ea, eb, ec, s, zi, dep, wa, wb, wc, rhw, mag, q;
        longint dx[3], dy[3];
        int idx;
        if (it.opcode == OP_LOAD) begin
            if (it.slot <= SLOT_MAX)
            begin
                tri_x[it.slot]   = it.vx;
                tri_y[it.slot]   = it.vy;
                tri_z[it.slot]   = it.vz;
                tri_rhw[it.slot] = it.vrhw;
            end
            return;
        end
        res = '{ST_REJECT, it.px, it.py, 8'd0, 8'd0, 8'd0, 16'd0};
        cx = it.px * 16 + 8;
        cy = it.py * 16 + 8;
        for (int k = 0; k < 3; k++)
        begin
            dx[k] = longint'(tri_x[k]) - cx;
            dy[k] = longint'(tri_y[k]) - cy;
        end
        ea = edge_fn(dx[1], dy[1], dx[2], dy[2]);
        eb = edge_fn(dx[2], dy[2], dx[0], dy[0]);
        ec = edge_fn(dx[0], dy[0], dx[1], dy[1]);
        s = ea + eb + ec;
        if (ea < 0 || eb < 0 || ec < 0 || s == 0)
        begin
            expected_frags = {expected_frags, res};
            return;
        end
        wa = (ea * 65536) / s;
        wb = (eb * 65536) / s;
        wc = (ec * 65536) / s;
        rhw = (wa * tri_rhw[0] + wb * tri_rhw[1] + wc * tri_rhw[2]) >>> 16;
        zi = wa * tri_z[0] + wb * tri_z[1] + wc * tri_z[2];
        if (rhw == 0)
            dep = 32767;
        else
        begin
            mag = (zi < 0) ? -zi : zi;
            q = mag / rhw;
            if (zi < 0)
                dep = (q > 32768) ? -32768 : -q;
            else
                dep = (q > 32767) ? 32767 : q;
        end
        res.depth = dep[15:0];
        idx = it.py * 256 + it.px;
        if (dep >= longint'(zbuf[idx]))
        begin
            res.status = ST_DEPTH_FAIL;
            expected_frags = {expected_frags, res};
            return;
        end
        zbuf[idx] = dep[15:0];
        res.r = blend(it.a, it.r, cbuf[idx][23:16]);
        res.g = blend(it.a, it.g, cbuf[idx][15:8]);
        res.b = blend(it.a, it.b, cbuf[idx][7:0]);
        cbuf[idx] = {res.r, res.g, res.b};
        res.status = ST_WRITTEN;
        expected_frags = {expected_frags, res};
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic item_t vertex(int slot, int x, int y, int z, int rhw);
        item_t it;
        it = '{default: '0};
        it.opcode = OP_LOAD;
        it.slot = 2'(slot);
        it.vx = 13'(x);
        it.vy = 13'(y);
        it.vz = 16'(z);
        it.vrhw = 24'(rhw);
        return it;
    endfunction

    function automatic item_t fragment(int x, int y, int r, int g, int b, int a);
        item_t it;
        it = '{default: '0};
        it.opcode = OP_FRAG;
        it.px = 8'(x);
        it.py = 8'(y);
        it.r = 8'(r);
        it.g = 8'(g);
        it.b = 8'(b);
        it.a = 8'(a);
        // unused fields carry noise, they must not matter
        it.slot = 2'($urandom);
        it.vx = 13'($urandom);
        it.vy = 13'($urandom);
        it.vz = 16'($urandom);
        it.vrhw = 24'($urandom);
        return it;
    endfunction

    task automatic enqueue(input item_t it);
        pending_items = {pending_items, it};
    endtask

    // driver
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (!calm && send_gap == 0 && $urandom_range(0, 15) == 0)
                send_gap = $urandom_range(1, 14);
            if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                item_t it;
                it = pending_items.pop_front();
                shade_fragment(it);
                in_ch.valid       <= 1'b1;
                in_ch.opcode      <= it.opcode;
                in_ch.vertex_slot <= it.slot;
                in_ch.vert_x      <= it.vx;
                in_ch.vert_y      <= it.vy;
                in_ch.vert_z      <= it.vz;
                in_ch.vert_rhw    <= it.vrhw;
                in_ch.pixel_x     <= it.px;
                in_ch.pixel_y     <= it.py;
                in_ch.src_r       <= it.r;
                in_ch.src_g       <= it.g;
                in_ch.src_b       <= it.b;
                in_ch.src_alpha   <= it.a;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // receiver stall control, with one long hold-off on request
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left = 3000;
            end
            else if (!calm && stall_left == 0 && $urandom_range(0, 15) == 0)
                stall_left = $urandom_range(1, 14);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_frags.size() == 0)
                report_mismatch("unexpected result, x", out_ch.out_x, -1);
            else
            begin
                frag_result_t e;
                e = expected_frags.pop_front();
                if (out_ch.status !== e.status)
                    report_mismatch("status", out_ch.status, e.status);
                if (out_ch.out_x !== e.x)
                    report_mismatch("out_x", out_ch.out_x, e.x);
                if (out_ch.out_y !== e.y)
                    report_mismatch("out_y", out_ch.out_y, e.y);
                if (out_ch.out_r !== e.r)
                    report_mismatch("out_r", out_ch.out_r, e.r);
                if (out_ch.out_g !== e.g)
                    report_mismatch("out_g", out_ch.out_g, e.g);
                if (out_ch.out_b !== e.b)
                    report_mismatch("out_b", out_ch.out_b, e.b);
                if (out_ch.out_depth !== e.depth)
                    report_mismatch("out_depth", $signed(out_ch.out_depth),
                                    $signed(e.depth));
            end
        end
    end

    // watchdog: cycles without any transfer; the store clear after reset counts too
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("*** FAILED ***");
            $finish;
        end
    end

    // random triangle: mostly sane ones around a small area, sometimes anything
    task automatic queue_triangle(input int cx, input int cy);
        int span;
        span = $urandom_range(16, 400);
        for (int k = 0; k < 3; k++)
        begin
            int x, y, z, rhw;
            x = cx * 16 + $urandom_range(0, 2 * span) - span;
            y = cy * 16 + $urandom_range(0, 2 * span) - span;
            x = (x < 0) ? 0 : (x > 8191 ? 8191 : x);
            y = (y < 0) ? 0 : (y > 8191 ? 8191 : y);
            z = $urandom_range(0, 65535);
            case ($urandom_range(0, 3))
                0: rhw = $urandom_range(1, 24'hFFFFFF);
                1: rhw = $urandom_range(1, 300);
                default: rhw = $urandom_range(16'h4000, 24'h2FFFF);
            endcase
            if ($urandom_range(0, 20) == 0)
                enqueue(vertex(3, $urandom, $urandom, $urandom, $urandom));
            enqueue(vertex(k, x, y, z, rhw));
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_ch.valid || expected_frags.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int count;
        errors = 0;
        idle_cycles = 0;
        stim_done = 0;
        calm = 0;
        hold_off_req = 0;
        for (int k = 0; k < 3; k++)
        begin
            tri_x[k] = '0;
            tri_y[k] = '0;
            tri_z[k] = '0;
            tri_rhw[k] = '0;
        end
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            zbuf[i] = DEPTH_FAR;
            cbuf[i] = '0;
        end
        in_ch.valid = 0;
        in_ch.opcode = 0;
        in_ch.vertex_slot = 0;
        in_ch.vert_x = 0;
        in_ch.vert_y = 0;
        in_ch.vert_z = 0;
        in_ch.vert_rhw = 0;
        in_ch.pixel_x = 0;
        in_ch.pixel_y = 0;
        in_ch.src_r = 0;
        in_ch.src_g = 0;
        in_ch.src_b = 0;
        in_ch.src_alpha = 0;
        out_ch.ready = 0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // directed: corners never loaded (degenerate), then a big triangle
        enqueue(fragment(0, 0, 255, 255, 255, 255));
        enqueue(vertex(0, 0, 0, -32768, 24'hFFFFFF));
        enqueue(vertex(1, 4096, 0, 32767, 1));
        enqueue(vertex(2, 0, 4096, 0, 65536));
        enqueue(vertex(3, 8191, 8191, -1, 5));          // ignored slot
        enqueue(fragment(0, 0, 255, 0, 128, 255));
        enqueue(fragment(0, 0, 1, 2, 3, 0));            // rejected like the one before: the triangle is clockwise
        enqueue(fragment(10, 20, 200, 100, 50, 128));
        enqueue(fragment(255, 255, 0, 0, 0, 0));        // outside
        enqueue(fragment(100, 100, 255, 255, 255, 1));
        enqueue(fragment(100, 100, 7, 7, 7, 254));
        // zero rhw everywhere, on a clockwise triangle, so the fragment rejects
        enqueue(vertex(0, 0, 0, 100, 0));
        enqueue(vertex(1, 8191, 0, 100, 0));
        enqueue(vertex(2, 0, 8191, 100, 0));
        enqueue(fragment(50, 50, 9, 9, 9, 9));
        // full-range corner fields, clockwise triangle rejects
        enqueue(vertex(0, 8191, 8191, 32767, 24'hFFFFFF));
        enqueue(vertex(1, 0, 8191, -32768, 1));
        enqueue(vertex(2, 8191, 0, 0, 24'hFFFFFF));
        enqueue(fragment(200, 200, 255, 255, 255, 255));
        enqueue(fragment(254, 1, 128, 64, 32, 16));
        wait_drained();

        // random: triangles followed by fragments mostly inside their bounds
        count = 20;
        while (count < 1750)
        begin
            int cx, cy, nfrag;
            cx = $urandom_range(0, 255);
            cy = $urandom_range(0, 255);
            queue_triangle(cx, cy);
            count += 3;
            nfrag = $urandom_range(3, 20);
            for (int f = 0; f < nfrag; f++)
            begin
                int fx, fy;
                if ($urandom_range(0, 9) == 0)
                begin
                    fx = $urandom_range(0, 255);
                    fy = $urandom_range(0, 255);
                end
                else
                begin
                    // small neighborhood so pixels get hit repeatedly
                    fx = (cx + $urandom_range(0, 16) - 8) & 8'hFF;
                    fy = (cy + $urandom_range(0, 16) - 8) & 8'hFF;
                end
                enqueue(fragment(fx, fy, $urandom, $urandom, $urandom, $urandom));
                count++;
            end
            if (count > 600 && count < 640)
            begin
                // long receiver hold-off while the sender keeps offering
                while (pending_items.size() > 0)
                    @(posedge clk);
                hold_off_req = 1;
                for (int f = 0; f < 30; f++)
                    enqueue(fragment(cx, cy, $urandom, $urandom, $urandom, $urandom));
                count += 30;
            end
            if (count > 1500)
                calm = 1;
            while (pending_items.size() > 40)
                @(posedge clk);
        end
        wait_drained();
        stim_done = 1;
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tfdb_pkg.sv
hdl/tfdb_in_if.sv
hdl/tfdb_out_if.sv
hdl/tfdb_div.sv
hdl/tfdb_front.sv
hdl/tfdb_queue.sv
hdl/tfdb_back.sv
hdl/triangle_fragment_depth_blend.sv
hdl/tfdb_checker.sv
bench/tb_triangle_fragment_depth_blend.sv
